@@ sv/utf8_vietnamese_tone_stripper_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 tone stripper assertion macros
// Concurrent check wrappers, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef UTF8_VIETNAMESE_TONE_STRIPPER_MACROS_SVH
`define UTF8_VIETNAMESE_TONE_STRIPPER_MACROS_SVH

`ifndef SYNTH

`define UVTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define UVTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define UVTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define UVTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/utf8vts_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 tone stripper package
// Word types, job type, constants and the code point to letter map.
// ----------------------------------------------------------------------------
package utf8vts_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_out_word;

    localparam int JOB_BYTES   = 4;
    localparam int IDX_W       = $clog2(JOB_BYTES);
    localparam int CNT_W       = $clog2(JOB_BYTES + 1);
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CODE_W      = 21;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      eos;
    } t_job;

    localparam logic [CODE_W-1:0] MARK_LO   = 21'h0300;
    localparam logic [CODE_W-1:0] MARK_HI   = 21'h036F;
    localparam logic [CODE_W-1:0] LATIN_LO  = 21'h00C0;
    localparam logic [CODE_W-1:0] LATIN_HI  = 21'h00FF;
    localparam logic [CODE_W-1:0] VIET_LO   = 21'h1EA0;
    localparam logic [CODE_W-1:0] VIET_HI   = 21'h1EF9;
    localparam logic [CODE_W-1:0] VIET_A_HI = 21'h1EB7;
    localparam logic [CODE_W-1:0] VIET_E_HI = 21'h1EC7;
    localparam logic [CODE_W-1:0] VIET_I_HI = 21'h1ECB;
    localparam logic [CODE_W-1:0] VIET_O_HI = 21'h1EE3;
    localparam logic [CODE_W-1:0] VIET_U_HI = 21'h1EF1;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CASE_BIT = 8'h20;

    function automatic logic [7:0] latin1_upper(input logic [4:0] idx);
        logic [7:0] r;
        case (idx) inside
            [5'd0:5'd3]:     r = CH_A;
            [5'd8:5'd10]:    r = CH_E;
            5'd12, 5'd13:    r = CH_I;
            5'd16:           r = CH_D;
            [5'd18:5'd21]:   r = CH_O;
            5'd25, 5'd26:    r = CH_U;
            5'd29:           r = CH_Y;
            default:         r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] map_code(input logic [CODE_W-1:0] code);
        logic [7:0] up;
        logic [7:0] r;
        up = 8'h00;
        r  = 8'h00;
        if (code >= LATIN_LO && code <= LATIN_HI) begin
            up = latin1_upper(code[4:0]);
            r  = (up != 8'h00 && code[5]) ? (up | CASE_BIT) : up;
        end else if (code >= VIET_LO && code <= VIET_HI) begin
            if (code <= VIET_A_HI) up = CH_A;
            else if (code <= VIET_E_HI) up = CH_E;
            else if (code <= VIET_I_HI) up = CH_I;
            else if (code <= VIET_O_HI) up = CH_O;
            else if (code <= VIET_U_HI) up = CH_U;
            else up = CH_Y;
            r = code[0] ? (up | CASE_BIT) : up;
        end else begin
            case (code)
                21'h0102: r = CH_A;
                21'h0103: r = CH_A | CASE_BIT;
                21'h0110: r = CH_D;
                21'h0111: r = CH_D | CASE_BIT;
                21'h0128: r = CH_I;
                21'h0129: r = CH_I | CASE_BIT;
                21'h0168: r = CH_U;
                21'h0169: r = CH_U | CASE_BIT;
                21'h01A0: r = CH_O;
                21'h01A1: r = CH_O | CASE_BIT;
                21'h01AF: r = CH_U;
                21'h01B0: r = CH_U | CASE_BIT;
                default:  r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

@@ sv/utf8vts_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 tone stripper front end
// Accepts input words, gathers sequences, decodes and classifies them,
// and issues at most one job of up to four output bytes per word.
// ----------------------------------------------------------------------------
module utf8vts_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  utf8vts_pkg::t_in_word i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_full,
    output logic                  o_push,
    output utf8vts_pkg::t_job     o_job
);
    import utf8vts_pkg::*;

    logic [2:0][7:0]   r_held, n_held;
    logic [1:0]        r_hc, n_hc;
    logic [2:0]        r_sl, n_sl;
    logic              r_vm, n_vm;

    logic              accept;
    logic              complete;
    logic [7:0]        b;
    logic              eos;
    logic [7:0]        s1, s2;
    logic [CODE_W-1:0] code;
    logic [7:0]        mapped;
    t_job              job;

    assign b        = i_in_data.in_byte;
    assign eos      = i_in_data.end_of_string;
    assign accept   = i_in_valid && !i_full;
    assign complete = (r_sl != 3'd0) && (({1'b0, r_hc} + 3'd1) >= r_sl);
    assign s1       = (r_sl == 3'd2) ? b : r_held[1];
    assign s2       = (r_sl == 3'd3) ? b : r_held[2];

    always_comb begin
        unique case (r_sl)
            3'd4:    code = {r_held[0][2:0], s1[5:0], s2[5:0], b[5:0]};
            3'd3:    code = {5'd0, r_held[0][3:0], s1[5:0], s2[5:0]};
            default: code = {10'd0, r_held[0][4:0], s1[5:0]};
        endcase
    end

    assign mapped = map_code(code);

    always_comb begin
        n_held  = r_held;
        n_hc    = r_hc;
        n_sl    = r_sl;
        n_vm    = r_vm;
        job     = '0;
        job.eos = eos;
        if (r_vm) begin
            job.bytes[0] = b;
            job.cnt      = CNT_W'(1);
        end else if (r_sl == 3'd0) begin
            job.bytes[0] = b;
            if (!b[7]) begin
                job.cnt = CNT_W'(1);
            end else begin
                n_held[0] = b;
                n_hc      = 2'd1;
                if (b[7:4] == 4'hF) n_sl = 3'd4;
                else if (b[7:4] == 4'hE) n_sl = 3'd3;
                else n_sl = 3'd2;
                job.cnt = eos ? CNT_W'(1) : CNT_W'(0);
            end
        end else if (complete) begin
            n_hc = 2'd0;
            n_sl = 3'd0;
            if (code >= MARK_LO && code <= MARK_HI) begin
                job.cnt = CNT_W'(0);
            end else if (code == '0) begin
                n_vm = 1'b1;
            end else if (mapped != 8'h00) begin
                job.bytes[0] = mapped;
                job.cnt      = CNT_W'(1);
            end else begin
                job.bytes = {b, s2, s1, r_held[0]};
                job.cnt   = CNT_W'(r_sl);
            end
        end else begin
            n_held[r_hc] = b;
            n_hc         = r_hc + 2'd1;
            if (eos) begin
                job.bytes[0] = r_held[0];
                job.bytes[1] = (r_hc == 2'd1) ? b : r_held[1];
                job.bytes[2] = b;
                job.cnt      = CNT_W'({1'b0, r_hc} + 3'd1);
            end
        end
        if (eos) begin
            n_hc = 2'd0;
            n_sl = 3'd0;
            n_vm = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 2'd0;
            r_sl <= 3'd0;
            r_vm <= 1'b0;
        end else if (accept) begin
            r_hc <= n_hc;
            r_sl <= n_sl;
            r_vm <= n_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = accept && (job.cnt != '0);
    assign o_job      = job;

endmodule

@@ sv/utf8vts_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 tone stripper job queue
// Small first-in first-out store of jobs between front and back ends.
// ----------------------------------------------------------------------------
module utf8vts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8vts_pkg::t_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output utf8vts_pkg::t_job o_job,
    output logic              o_empty
);
    import utf8vts_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + QCNT_W'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ sv/utf8vts_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 tone stripper back end
// Unpacks the head job into output words, one byte per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module utf8vts_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  utf8vts_pkg::t_job      i_job,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output utf8vts_pkg::t_out_word o_out_data,
    input  logic                   i_out_stall
);
    import utf8vts_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_word        r_word;
    logic             load;
    logic             last;

    assign load  = !i_empty && (!r_valid || !i_out_stall);
    assign last  = (CNT_W'(r_idx) + CNT_W'(1)) == i_job.cnt;
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= last ? '0 : r_idx + IDX_W'(1);
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word.out_byte    <= i_job.bytes[r_idx];
            r_word.run_last    <= last;
            r_word.string_done <= last && i_job.eos;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

endmodule

@@ sv/utf8_vietnamese_tone_stripper.sv @@
// ----------------------------------------------------------------------------
// UTF-8 Vietnamese tone stripper
// Takes one UTF-8 byte per cycle unless stalled and returns Vietnamese letters as
// plain ASCII, dropping combining marks and passing other sequences through.
// ----------------------------------------------------------------------------
// The block accepts one input byte every cycle while its eight-entry job queue
// has room. The front end decodes a whole sequence in the cycle its final byte
// arrives and queues a job of up to four bytes; the back end sends one output
// word per cycle from the head job while the output is not stalled, so a
// sequence re-emitted byte for byte gives one output word per byte. Since output
// never outruns input, the queue absorbs such bursts and input is taken one byte
// per cycle unless the output side stalls; output runs at up to one word per
// cycle. A result passes through the job queue and then the output register.
`include "utf8_vietnamese_tone_stripper_macros.svh"

module utf8_vietnamese_tone_stripper (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  utf8vts_pkg::t_in_word  i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output utf8vts_pkg::t_out_word o_out_data,
    input  logic                   i_out_stall
);
    import utf8vts_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_job push_job, head_job;

    utf8vts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    utf8vts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    utf8vts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    `UVTS_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    `UVTS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `UVTS_ASSERT_IMP(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.string_done, o_out_data.run_last)
    `UVTS_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, q_push && !q_pop, !q_empty)

endmodule
